### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers used by the matcher back end; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define CRSM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define CRSM_NEVER(lbl, clk, rst, cond) \
  `CRSM_ASSERT(lbl, clk, rst, !(cond))

`else

`define CRSM_ASSERT(lbl, clk, rst, prop)
`define CRSM_NEVER(lbl, clk, rst, cond)

`endif

`endif

### rtl/crsm_pkg.sv
// ----------------------------------------------------------------------------
// Cron schedule matcher package
// Item types, job type between the front and back ends, and fixed constants.
// ----------------------------------------------------------------------------
package crsm_pkg;

  localparam int ENTRY_W    = 4;
  localparam int CFG_W      = 5;
  localparam int SLOT_COUNT = 2 ** ENTRY_W;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // no minute seen yet
  localparam logic [5:0] NO_MINUTE = 6'd63;

  // first value out of range for minute, hour and weekday; last valid month
  localparam logic [5:0] MINUTE_END  = 6'd60;
  localparam logic [4:0] HOUR_END    = 5'd24;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [2:0] WEEKDAY_END = 3'd7;

  typedef struct packed {
    logic                action;
    logic [ENTRY_W-1:0]  entry_index;
    logic [59:0]         minute_mask;
    logic [23:0]         hour_mask;
    logic [30:0]         day_mask;
    logic [11:0]         month_mask;
    logic [6:0]          weekday_mask;
    logic [5:0]          minute;
    logic [4:0]          hour;
    logic [4:0]          day;
    logic [3:0]          month;
    logic [2:0]          weekday;
  } cron_item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] matched_entry;
    logic               last_match;
  } cron_result_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
  } sched_t;

  // Bit positions of the tick time in each mask; zero when ok is low.
  typedef struct packed {
    logic       ok;
    logic [5:0] minute_pos;
    logic [4:0] hour_pos;
    logic [4:0] day_pos;
    logic [3:0] month_pos;
    logic [2:0] weekday_pos;
  } tick_pos_t;

  typedef struct packed {
    logic               action;
    logic [ENTRY_W-1:0] slot;
    sched_t             sched;
    tick_pos_t          pos;
  } job_t;

endpackage

### rtl/crsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/crsm_queue.sv
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue of a generic item type.
// ----------------------------------------------------------------------------
module crsm_queue #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic valid
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  T                slots [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign dout    = slots[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/crsm_front.sv
// ----------------------------------------------------------------------------
// Matcher front end
// Accept items, drop repeated minutes and loads to out-of-range slots, turn
// tick times into mask bit positions and queue the resulting jobs.
// ----------------------------------------------------------------------------
module crsm_front
  import crsm_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cron_item_t item,
  output logic       full,
  output logic       jq_push,
  output job_t       jq_job,
  input  logic       jq_full
);

  localparam logic [ENTRY_W:0] SLOT_END = (ENTRY_W + 1)'(DEPTH);

  logic [5:0] last_minute;
  logic       take;
  logic       tick;
  logic       new_minute;
  logic       slot_ok;
  logic       time_ok;

  assign full = jq_full;
  assign take = push & ~jq_full;
  assign tick = (item.action == ACT_TICK);

  always_comb begin
    new_minute = (item.minute != last_minute);
    slot_ok    = ({1'b0, item.entry_index} < SLOT_END);
    time_ok    = (item.minute < MINUTE_END) && (item.hour < HOUR_END)
              && (item.day != '0) && (item.month != '0)
              && (item.month <= MONTH_LAST) && (item.weekday < WEEKDAY_END);
    jq_push    = take & (tick ? new_minute : slot_ok);

    jq_job.action = item.action;
    jq_job.slot   = item.entry_index;
    jq_job.sched  = '{minute_mask:  item.minute_mask,
                      hour_mask:    item.hour_mask,
                      day_mask:     item.day_mask,
                      month_mask:   item.month_mask,
                      weekday_mask: item.weekday_mask};
    // zero the positions of a bad time so mask lookups stay in range
    jq_job.pos    = '0;
    if (time_ok) begin
      jq_job.pos.ok          = 1'b1;
      jq_job.pos.minute_pos  = item.minute;
      jq_job.pos.hour_pos    = item.hour;
      jq_job.pos.day_pos     = item.day - 5'd1;
      jq_job.pos.month_pos   = item.month - 4'd1;
      jq_job.pos.weekday_pos = item.weekday;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_minute <= NO_MINUTE;
    end else if (take && tick && new_minute) begin
      last_minute <= item.minute;
    end
  end

endmodule

### rtl/crsm_back.sv
// ----------------------------------------------------------------------------
// Matcher back end
// Write loaded schedules to the entry RAM and scan it once per minute change,
// holding one match back so the final one can be flagged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crsm_back
  import crsm_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] entries_in_use,
  input  logic             jq_valid,
  input  job_t             jq_job,
  output logic             jq_pop,
  output logic             out_push,
  output cron_result_t     out_res,
  input  logic             out_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         lim;
  tick_pos_t             tm;
  logic                  d_vld;
  logic [AW-1:0]         d_idx;
  logic                  pend_vld;
  logic [AW-1:0]         pend_idx;

  logic [$bits(sched_t)-1:0] ram_rdata;
  sched_t                sched;
  logic                  ram_we;
  logic                  rd_en;
  logic                  scanning;
  logic                  hit;
  logic                  chk_push;
  logic                  stall;
  logic                  at_end;
  logic [CFG_W-1:0]      sat_count;

  always_comb begin
    scanning  = (state == ST_SCAN);
    sched     = sched_t'(ram_rdata);
    hit       = tm.ok & sched.minute_mask[tm.minute_pos] & sched.hour_mask[tm.hour_pos]
              & sched.day_mask[tm.day_pos] & sched.month_mask[tm.month_pos]
              & sched.weekday_mask[tm.weekday_pos];
    // a new match releases the one held back
    chk_push  = d_vld & hit & pend_vld;
    stall     = chk_push & out_full;
    at_end    = scanning & (idx == lim) & ~d_vld;
    out_push  = (chk_push | (at_end & pend_vld)) & ~out_full;
    out_res   = '{matched_entry: ENTRY_W'(pend_idx), last_match: at_end};
    rd_en     = scanning & (idx != lim) & ~stall;
    jq_pop    = (state == ST_IDLE) & jq_valid;
    ram_we    = jq_pop & (jq_job.action == ACT_LOAD);
    sat_count = (entries_in_use > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : entries_in_use;
  end

  crsm_ram #(
    .WIDTH ($bits(sched_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (jq_job.slot[AW-1:0]),
    .wdata (jq_job.sched),
    .re    (rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      lim      <= '0;
      d_vld    <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (jq_pop && jq_job.action == ACT_TICK) begin
            state <= ST_SCAN;
            idx   <= '0;
            lim   <= CW'(sat_count);
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          if (!stall) begin
            d_vld <= rd_en;
          end
          if (d_vld && !stall && hit) begin
            pend_vld <= 1'b1;
          end
          if (at_end && (!pend_vld || !out_full)) begin
            state    <= ST_IDLE;
            pend_vld <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      tm <= jq_job.pos;
    end
    if (rd_en) begin
      d_idx <= idx[AW-1:0];
    end
    if (d_vld && !stall && hit) begin
      pend_idx <= d_idx;
    end
  end

  `CRSM_ASSERT(a_push_has_room, clk, rst, out_push |-> !out_full)
  `CRSM_ASSERT(a_idx_in_bound, clk, rst, scanning |-> (idx <= lim))
  `CRSM_ASSERT(a_data_in_scan, clk, rst, d_vld |-> (scanning && (CW'(d_idx) < lim)))
  `CRSM_ASSERT(a_end_clears, clk, rst, (at_end && out_push) |=> (!pend_vld && state == ST_IDLE))
  `CRSM_NEVER(a_no_load_in_scan, clk, rst, ram_we && scanning)

endmodule

### rtl/cron_schedule_matcher.sv
// ----------------------------------------------------------------------------
// Cron schedule matcher
// Both channels behave as queues. Input: drive item and push; the item is
// taken on a clock edge with push high and full low. A load item
// (action 0) writes one entry's five masks; a tick item (action 1) carries
// the current time and is acted on only when its minute changed. Results:
// while empty is low, result holds the oldest matched entry index, with
// last_match set on the final match of a tick; pop with empty low takes it.
// A tick with no match gives no result. Write entries_in_use through
// cfg_we/cfg_wdata while idle; it saturates to the entry count.
// Throughput: the front takes one item a cycle while its two-job queue has
// room; a tick with an unchanged minute is dropped there. The back writes a
// load to the entry RAM as it pops it and scans a tick over the N entries in
// use, one entry RAM read per cycle while the result queue has room. A tick's
// first result reaches the result queue when its second match is found, or
// at the end of the scan when it matches once. A stalled receiver fills the
// two-slot result queue, which holds the scan, then the job queue, then
// raises full.
// Reset clears the queues, the scan, the last minute seen (to none) and
// entries_in_use; entry contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module cron_schedule_matcher
  import crsm_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cron_item_t       item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output cron_result_t     result,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // slot indexes are four bits wide, so at most 16 entries exist
  localparam int DEPTH = (MAX_ENTRIES < SLOT_COUNT) ? MAX_ENTRIES : SLOT_COUNT;

  logic [CFG_W-1:0] entries_in_use;
  logic             jq_push;
  job_t             jq_din;
  logic             jq_full;
  logic             jq_pop;
  job_t             jq_dout;
  logic             jq_valid;
  logic             out_push;
  cron_result_t     out_res;
  logic             out_full;
  logic             out_valid;

  // Hold the entry count until the next write.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // Front: accept, filter and classify.
  crsm_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .jq_push (jq_push),
    .jq_job  (jq_din),
    .jq_full (jq_full)
  );

  // Jobs in arrival order, so loads and scans never overtake each other.
  crsm_queue #(
    .T     (job_t),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .valid (jq_valid)
  );

  // Back: entry store and scan.
  crsm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entries_in_use (entries_in_use),
    .jq_valid       (jq_valid),
    .jq_job         (jq_dout),
    .jq_pop         (jq_pop),
    .out_push       (out_push),
    .out_res        (out_res),
    .out_full       (out_full)
  );

  // Result queue parts the scan from the receiver.
  crsm_queue #(
    .T     (cron_result_t),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_res),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .valid (out_valid)
  );

  assign empty = ~out_valid;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cron schedule matcher testbench
// Loads schedule entries and sends time ticks under random idling on both
// sides, works out the matched entry indices of each tick and checks every
// result item, in order, against them.
// ----------------------------------------------------------------------------
module tb;
  import crsm_pkg::*;

  // Cycles to let the back end finish a scan that may give no result
  localparam int SETTLE_CYCLES = 64;
  // Long hold-off of the result side, to fill the block up
  localparam int HOLD_CYCLES   = 400;
  // Cycles with no item moving on either side before the run is abandoned
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 40;
  localparam int PHASE_COUNT   = 8;
  localparam int HOLD_PHASE    = 6;
  localparam int STEADY_PHASE  = 7;
  localparam int RANDOM_PHASE  = 3;
  // entries_in_use per phase; the random phase draws its own value
  localparam int PLAN [PHASE_COUNT] = '{16, 31, 1, 9, 0, 17, 16, 16};

  typedef enum int {DENSITY_FULL, DENSITY_NONE, DENSITY_HALF, DENSITY_HIGH} density_t;

  // Holds its own copy of the entry store, the last minute and the scan
  // length; turns each accepted item into the match items it should give.
  class match_book_t;
    sched_t       entry_store [SLOT_COUNT];
    logic [5:0]   last_minute;
    int unsigned  scan_len;
    cron_result_t due_matches [$];
    int unsigned  errors;

    function new();
      last_minute = NO_MINUTE;
      scan_len    = 0;
      errors      = 0;
    endfunction

    function void set_entries(logic [CFG_W-1:0] value);
      scan_len = (value > SLOT_COUNT) ? SLOT_COUNT : value;
    endfunction

    function bit entry_hits(sched_t s, cron_item_t t);
      if (t.minute >= MINUTE_END || !s.minute_mask[t.minute]) return 1'b0;
      if (t.hour >= HOUR_END || !s.hour_mask[t.hour]) return 1'b0;
      if (t.day == 5'd0 || !s.day_mask[t.day - 5'd1]) return 1'b0;
      if (t.month == 4'd0 || t.month > MONTH_LAST || !s.month_mask[t.month - 4'd1])
        return 1'b0;
      if (t.weekday >= WEEKDAY_END || !s.weekday_mask[t.weekday]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(cron_item_t t);
      int           found [$];
      cron_result_t r;
      if (t.action == ACT_LOAD) begin
        entry_store[t.entry_index] = {t.minute_mask, t.hour_mask, t.day_mask,
                                      t.month_mask, t.weekday_mask};
        return;
      end
      // same minute as before: nothing to do
      if (t.minute == last_minute) return;
      last_minute = t.minute;
      for (int i = 0; i < scan_len; i++)
        if (entry_hits(entry_store[i], t)) found = {found, i};
      foreach (found[k]) begin
        r.matched_entry = ENTRY_W'(found[k]);
        r.last_match    = (k == found.size() - 1);
        due_matches     = {due_matches, r};
      end
    endfunction

    function void check_result(cron_result_t got);
      cron_result_t want;
      if (due_matches.size() == 0) begin
        $display("%0t: unexpected result: expected none, got entry %0d last %0b",
                 $time, got.matched_entry, got.last_match);
        errors++;
        return;
      end
      want = due_matches.pop_front();
      if (got.matched_entry !== want.matched_entry) begin
        $display("%0t: matched_entry mismatch: expected %0d, got %0d",
                 $time, want.matched_entry, got.matched_entry);
        errors++;
      end
      if (got.last_match !== want.last_match) begin
        $display("%0t: last_match mismatch: expected %0b, got %0b",
                 $time, want.last_match, got.last_match);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;
  cron_item_t         in_item;
  cron_result_t       out_result;

  match_book_t book;
  logic [5:0]  last_tick_min = NO_MINUTE;  // minute of the last tick sent
  bit          steady        = 1'b0;       // no idling on either side
  bit          hold_results  = 1'b0;       // ask the result side for a long hold-off
  int unsigned quiet_cycles  = 0;

  always #6 clk = ~clk;

  cron_schedule_matcher #(
    .MAX_ENTRIES(SLOT_COUNT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (in_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (out_result),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [191:0] wide_random();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random item: every field filled, so ignored fields carry noise too
  function automatic cron_item_t noise_item();
    logic [191:0] raw;
    raw = wide_random();
    return cron_item_t'(raw[$bits(cron_item_t)-1:0]);
  endfunction

  // Masks of one entry; dense masks keep matches frequent
  function automatic sched_t rand_sched();
    logic [191:0] raw;
    int unsigned  r;
    density_t     d;
    r = $urandom_range(99);
    if (r < 10) d = DENSITY_FULL;
    else if (r < 15) d = DENSITY_NONE;
    else if (r < 45) d = DENSITY_HALF;
    else d = DENSITY_HIGH;
    raw = wide_random();
    case (d)
      DENSITY_FULL: raw = '1;
      DENSITY_NONE: raw = '0;
      DENSITY_HIGH: raw = raw | wide_random() | wide_random();
      default: ;
    endcase
    return sched_t'(raw[$bits(sched_t)-1:0]);
  endfunction

  // Offer one item and hold it until taken, then idle for a while
  task automatic send_item(input cron_item_t t);
    int unsigned gap;
    in_item <= t;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [ENTRY_W-1:0] slot, input sched_t s);
    cron_item_t t;
    t = noise_item();
    t.action      = ACT_LOAD;
    t.entry_index = slot;
    {t.minute_mask, t.hour_mask, t.day_mask, t.month_mask, t.weekday_mask} = s;
    send_item(t);
  endtask

  task automatic send_tick(input logic [5:0] mi, input logic [4:0] hr,
                           input logic [4:0] dy, input logic [3:0] mo,
                           input logic [2:0] wd);
    cron_item_t t;
    t = noise_item();
    t.action  = ACT_TICK;
    t.minute  = mi;
    t.hour    = hr;
    t.day     = dy;
    t.month   = mo;
    t.weekday = wd;
    last_tick_min = mi;
    send_item(t);
  endtask

  // Mostly valid, changing times; now and then a repeated minute or a field
  // out of range
  task automatic send_rand_tick();
    logic [5:0]  mi;
    logic [4:0]  hr;
    logic [4:0]  dy;
    logic [3:0]  mo;
    logic [2:0]  wd;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) mi = last_tick_min;
    else if (r < 12) mi = 6'($urandom_range(63, 60));
    else mi = 6'($urandom_range(59, 0));
    hr = ($urandom_range(99) < 4) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23, 0));
    dy = ($urandom_range(99) < 3) ? 5'd0 : 5'($urandom_range(31, 1));
    r = $urandom_range(99);
    if (r < 2) mo = 4'd0;
    else if (r < 4) mo = 4'($urandom_range(15, 13));
    else mo = 4'($urandom_range(12, 1));
    wd = ($urandom_range(99) < 3) ? WEEKDAY_END : 3'($urandom_range(6, 0));
    send_tick(mi, hr, dy, mo, wd);
  endtask

  // Drop push, wait for every outstanding match, then let any silent scan
  // run out
  task automatic settle();
    push <= 1'b0;
    while (book.due_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write entries_in_use while the block is idle
  task automatic write_entries(input logic [CFG_W-1:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_entries(value);
  endtask

  // Record accepted items and check result items as they are taken
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) book.note_item(in_item);
      if (pop && !empty) book.check_result(out_result);
    end
  end

  // Watchdog: count cycles in which nothing moves on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog: nothing moved for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: pop with random stalls, plus one long hold-off on request
  initial begin : result_side
    int unsigned stall;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      stall = steady ? 0 : idle_len();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  initial begin : stimulus
    int unsigned span;
    book      = new();
    rst       = 1'b1;
    push      = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_item   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    write_entries(CFG_W'(0));
    // minute 63 equals the reset value: treated as unchanged
    send_tick(6'd63, 5'd0, 5'd1, 4'd1, 3'd0);
    // no entries in use: the minute is recorded but nothing matches
    send_tick(6'd10, 5'd5, 5'd5, 4'd5, 3'd5);
    // slot 0 matches any valid time, slot 1 never, slot 2 only at the
    // extremes, slot 3 only at the top of every range
    send_load(4'd0, '1);
    send_load(4'd1, '0);
    send_load(4'd2, {{1'b1, 58'd0, 1'b1}, {1'b1, 22'd0, 1'b1}, {1'b1, 29'd0, 1'b1},
                     {1'b1, 10'd0, 1'b1}, {1'b1, 5'd0, 1'b1}});
    send_load(4'd3, {{1'b1, 59'd0}, {1'b1, 23'd0}, {1'b1, 30'd0}, {1'b1, 11'd0},
                     {1'b1, 6'd0}});
    write_entries(CFG_W'(4));
    send_tick(6'd0, 5'd0, 5'd1, 4'd1, 3'd0);
    send_tick(6'd59, 5'd23, 5'd31, 4'd12, 3'd6);
    // unchanged minute: no result
    send_tick(6'd59, 5'd23, 5'd31, 4'd12, 3'd6);
    // each field out of range in turn
    send_tick(6'd60, 5'd1, 5'd2, 4'd2, 3'd1);
    send_tick(6'd63, 5'd1, 5'd2, 4'd2, 3'd1);
    send_tick(6'd1, 5'd24, 5'd2, 4'd2, 3'd1);
    send_tick(6'd2, 5'd31, 5'd2, 4'd2, 3'd1);
    send_tick(6'd3, 5'd1, 5'd0, 4'd2, 3'd1);
    send_tick(6'd4, 5'd1, 5'd2, 4'd0, 3'd1);
    send_tick(6'd5, 5'd1, 5'd2, 4'd13, 3'd1);
    send_tick(6'd6, 5'd1, 5'd2, 4'd15, 3'd1);
    send_tick(6'd7, 5'd1, 5'd2, 4'd2, 3'd7);
    // a single match, flagged as the last
    send_tick(6'd30, 5'd12, 5'd15, 4'd6, 3'd3);

    // ---- random part ----
    // fill every slot before any wider scan can read it
    for (int s = 0; s < SLOT_COUNT; s++) begin
      send_load(ENTRY_W'(s), rand_sched());
      send_rand_tick();
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      span = (p == RANDOM_PHASE) ? $urandom_range(15, 2) : PLAN[p];
      write_entries(CFG_W'(span));
      steady = (p == STEADY_PHASE);
      // hold the result side off while items keep coming, so full rises
      if (p == HOLD_PHASE) hold_results = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 25)
          send_load(ENTRY_W'($urandom_range(SLOT_COUNT - 1, 0)), rand_sched());
        else
          send_rand_tick();
      end
    end

    settle();
    if (book.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/crsm_pkg.sv
rtl/crsm_ram.sv
rtl/crsm_queue.sv
rtl/crsm_front.sv
rtl/crsm_back.sv
rtl/cron_schedule_matcher.sv
tb/tb.sv
